FILE: src/crossfade_fade_gain_soft_clip_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the crossfade gain and soft clipper block
// Shared property forms, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CROSSFADE_FADE_GAIN_SOFT_CLIP_DEFINES_SVH
`define CROSSFADE_FADE_GAIN_SOFT_CLIP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFGSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFGSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cfgsc_pkg.sv
// ----------------------------------------------------------------------------
// cfgsc_pkg
// Command and status types and fixed codes shared by the controller and
// the datapath of the crossfade gain and soft clipper.
// ----------------------------------------------------------------------------
package cfgsc_pkg;

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_REPEAT = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [2:0] REG_MASTER     = 3'd0;
  localparam logic [2:0] REG_XF_LEN     = 3'd1;
  localparam logic [2:0] REG_FI_LEN     = 3'd2;
  localparam logic [2:0] REG_FO_OFF     = 3'd3;
  localparam logic [2:0] REG_FO_OFF_REP = 3'd4;
  localparam logic [2:0] REG_FO_LEN     = 3'd5;

  localparam logic [1:0] F_XF = 2'd0;
  localparam logic [1:0] F_FI = 2'd1;
  localparam logic [1:0] F_FO = 2'd2;

  localparam int DIV_STEPS = 15;

  typedef struct packed {
    logic       accept;
    logic       prep;
    logic [1:0] fsel;
    logic       div_load;
    logic       div_step;
    logic       apply;
    logic       chan;
    logic       mul_in;
    logic       mul_old;
    logic       sum;
    logic       clip_a;
    logic       clip_b;
    logic       clip_c;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_frame;
    logic factor_on;
  } dp_stat_t;

endpackage

FILE: src/cfgsc_ctrl.sv
// ----------------------------------------------------------------------------
// cfgsc_ctrl
// Sequencer that walks one frame through the three gain factors, the two
// channel mixes and the soft clipper, and owns the output handshake.
// ----------------------------------------------------------------------------
`include "crossfade_fade_gain_soft_clip_defines.svh"

module cfgsc_ctrl
  import cfgsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_DSEL  = 12'b000000000100,
    S_DIV   = 12'b000000001000,
    S_APPLY = 12'b000000010000,
    S_MULI  = 12'b000000100000,
    S_MULO  = 12'b000001000000,
    S_SUM   = 12'b000010000000,
    S_CLA   = 12'b000100000000,
    S_CLB   = 12'b001000000000,
    S_CLC   = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] fsel, fsel_next;
  logic [3:0] iter, iter_next;
  logic       chan, chan_next;
  logic       out_valid_next;
  logic       load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    fsel_next      = fsel;
    iter_next      = iter;
    chan_next      = chan;
    cmd            = '0;
    cmd.fsel       = fsel;
    cmd.chan       = chan;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && stat.is_frame) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        fsel_next  = F_XF;
        state_next = S_DSEL;
      end
      S_DSEL: begin
        if (stat.factor_on) begin
          cmd.div_load = 1'b1;
          iter_next    = '0;
          state_next   = S_DIV;
        end else if (fsel == F_FO) begin
          chan_next  = 1'b0;
          state_next = S_MULI;
        end else begin
          fsel_next = fsel + 2'd1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 4'd1;
        if (iter == 4'(DIV_STEPS - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (fsel == F_FO) begin
          chan_next  = 1'b0;
          state_next = S_MULI;
        end else begin
          fsel_next  = fsel + 2'd1;
          state_next = S_DSEL;
        end
      end
      S_MULI: begin
        cmd.mul_in = 1'b1;
        state_next = S_MULO;
      end
      S_MULO: begin
        cmd.mul_old = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CLA;
      end
      S_CLA: begin
        cmd.clip_a = 1'b1;
        state_next = S_CLB;
      end
      S_CLB: begin
        cmd.clip_b = 1'b1;
        state_next = S_CLC;
      end
      S_CLC: begin
        cmd.clip_c = 1'b1;
        if (chan) begin
          state_next = S_FIN;
        end else begin
          chan_next  = 1'b1;
          state_next = S_MULI;
        end
      end
      S_FIN: begin
        if (load_out) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fsel      <= F_XF;
      iter      <= '0;
      chan      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fsel      <= fsel_next;
      iter      <= iter_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  `CFGSC_ASSERT_SAME(a_div_bound, state == S_DIV, iter < 4'(DIV_STEPS), "divide overran")
  `CFGSC_ASSERT_NEXT(a_out_load, load_out, out_valid && state == S_IDLE, "result not posted")
  `CFGSC_ASSERT_SAME(a_apply_after_div, state == S_APPLY, $past(state) == S_DIV, "apply without divide")

endmodule

FILE: src/cfgsc_dp.sv
// ----------------------------------------------------------------------------
// cfgsc_dp
// Configuration registers, envelope counters, shared restoring divider,
// gain multipliers, channel mixer and table based soft clipper.
// ----------------------------------------------------------------------------
module cfgsc_dp
  import cfgsc_pkg::*;
#(
  parameter int COUNT_WIDTH      = 24,
  parameter int SAMPLE_WIDTH     = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [24:0]                    cfg_data,
  input  logic [1:0]                     cmd_code,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right,
  input  logic signed [SAMPLE_WIDTH-1:0] old_left,
  input  logic signed [SAMPLE_WIDTH-1:0] old_right,
  output logic signed [15:0]             out_left,
  output logic signed [15:0]             out_right,
  input  ctl_cmd_t                       cmd,
  output dp_stat_t                       stat
);

  localparam int CW  = COUNT_WIDTH;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int DW  = ((CW > 25) ? CW : 25) + 2;
  localparam int NW  = DW - 1;
  localparam int PW  = SW + 17;
  localparam int XW  = SW + 18;
  localparam int FW  = XW + 13;
  localparam int AIW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int EW  = CW + 24;
  localparam logic [XW-1:0] ONE  = XW'(1) << (SW + 10);
  localparam logic [XW-1:0] HALF = XW'(1) << (SW - 5);
  localparam logic [63:0] TANH_Y  = (64'd1 << 33) / TANH_TABLE_DEPTH;
  localparam logic [63:0] TANH_Y2 = (TANH_Y * TANH_Y) >> 30;
  localparam logic [63:0] TANH_P3 = (TANH_Y * TANH_Y2) >> 30;
  localparam logic [63:0] TANH_P5 = (TANH_P3 * TANH_Y2) >> 30;
  localparam logic [63:0] TANH_P7 = (TANH_P5 * TANH_Y2) >> 30;
  localparam logic [63:0] TANH_P9 = (TANH_P7 * TANH_Y2) >> 30;
  localparam logic [63:0] TANH_S  = TANH_Y - TANH_P3 / 64'd3 + (64'd2 * TANH_P5) / 64'd15
                                    - (64'd17 * TANH_P7) / 64'd315
                                    + (64'd62 * TANH_P9) / 64'd2835;

  typedef logic [30:0] tab_t [0:TANH_TABLE_DEPTH];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab(input logic [63:0] s);
    tab_t        tb;
    logic [63:0] t, den;
    t     = '0;
    tb[0] = '0;
    for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
      den       = (64'd1 << 30) + ((t * s) >> 30);
      t         = udiv64((t + s) << 30, den);
      tb[i + 1] = t[30:0];
    end
    return tb;
  endfunction

  localparam tab_t TANH_TAB = build_tab(TANH_S);

  logic [15:0] gain_level;
  logic [23:0] xf_len, fi_len, fo_len;
  logic [24:0] fo_off, fo_off_rep;

  logic [CW-1:0] xf_pos, fi_pos, elapsed;
  logic          outgoing_live, entry_seen, use_rep, xf;

  logic signed [SW-1:0] s_il, s_ir, s_ol, s_or;
  logic [15:0]          g, gout;

  logic [23:0] rem;
  logic [14:0] quo;
  logic        sat;

  logic signed [PW-1:0] p_in, p_old;
  logic [XW-1:0]        a;
  logic                 neg;
  logic                 lin_zone;
  logic [15:0]          smag;
  logic [30:0]          t_lo, t_hi;
  logic [15:0]          frac;
  logic [46:0]          prod;
  logic [15:0]          res_l;

  logic                 accept;
  logic signed [DW-1:0] d;
  logic [24:0]          off_sel;
  logic                 fi_on, xf_wrap;
  logic [NW-1:0]        num;
  logic [23:0]          den;
  logic [24:0]          r2;
  logic [15:0]          f_ramp, f_fo, factor;
  logic [31:0]          gprod, goprod;
  logic [CW-1:0]        xf_inc, el_inc, fi_inc;
  logic signed [SW-1:0] mix_in, mix_old;
  logic signed [XW-1:0] x;
  logic [XW-1:0]        e, smag_w;
  logic [FW-1:0]        fe, fe_idx, fe_frac;
  logic                 big;
  logic [AIW-1:0]       lo_idx, hi_idx;
  logic [31:0]          th, th_r;
  logic [15:0]          mag, res;

  assign accept = cmd.accept;

  assign off_sel = use_rep ? fo_off_rep : fo_off;
  assign d = $signed({{(DW - CW){1'b0}}, elapsed}) - $signed({{(DW - 25){off_sel[24]}}, off_sel});
  assign fi_on = (fi_len != 24'd0) && ({{24{1'b0}}, fi_pos} < {{CW{1'b0}}, fi_len});

  always_comb begin
    stat.is_frame = (cmd_code == CMD_FRAME);
    case (cmd.fsel)
      F_XF: begin
        stat.factor_on = xf;
        num            = NW'(xf_pos);
        den            = xf_len;
      end
      F_FI: begin
        stat.factor_on = fi_on;
        num            = NW'(fi_pos);
        den            = fi_len;
      end
      F_FO: begin
        stat.factor_on = (fo_len != 24'd0) && !d[DW-1];
        num            = d[NW-1:0];
        den            = fo_len;
      end
      default: begin
        stat.factor_on = 1'b0;
        num            = '0;
        den            = fo_len;
      end
    endcase
  end

  assign r2     = {rem, 1'b0};
  assign f_ramp = sat ? 16'h8000 : {1'b0, quo};
  assign f_fo   = sat ? 16'h0000 : 16'h8000 - {1'b0, quo};
  assign factor = (cmd.fsel == F_FO) ? f_fo : f_ramp;
  assign gprod  = 32'(g) * 32'(factor);
  assign goprod = 32'(gain_level) * 32'(16'h8000 - f_ramp);

  assign xf_inc  = (xf_pos == '1) ? xf_pos : xf_pos + 1'b1;
  assign el_inc  = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign fi_inc  = (fi_pos == '1) ? fi_pos : fi_pos + 1'b1;
  assign xf_wrap = ({{24{1'b0}}, xf_inc} >= {{CW{1'b0}}, xf_len});

  assign mix_in  = cmd.chan ? s_ir : s_il;
  assign mix_old = cmd.chan ? s_or : s_ol;
  assign x       = XW'(p_in) + XW'(p_old);

  assign e       = a - ONE;
  assign fe      = {13'd0, e} * FW'(TANH_TABLE_DEPTH);
  assign fe_idx  = fe >> (SW + 13);
  assign fe_frac = fe >> (SW - 3);
  assign big     = fe_idx >= FW'(TANH_TABLE_DEPTH);
  assign lo_idx  = big ? AIW'(TANH_TABLE_DEPTH) : fe_idx[AIW-1:0];
  assign hi_idx  = big ? AIW'(TANH_TABLE_DEPTH) : fe_idx[AIW-1:0] + 1'b1;
  assign smag_w  = (a + HALF) >> (SW - 4);

  assign th   = 32'(t_lo) + 32'(prod >> 16);
  assign th_r = (th + 32'h0001_0000) >> 17;
  assign mag  = lin_zone ? smag : 16'd16384 + th_r[15:0];
  assign res  = neg ? 16'd0 - mag : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_level    <= 16'h8000;
      xf_len        <= '0;
      fi_len        <= '0;
      fo_len        <= '0;
      fo_off        <= '0;
      fo_off_rep    <= '0;
      xf_pos        <= '0;
      fi_pos        <= '0;
      elapsed       <= '0;
      outgoing_live <= 1'b0;
      entry_seen    <= 1'b0;
      use_rep       <= 1'b0;
      xf            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MASTER:     gain_level <= cfg_data[15:0];
          REG_XF_LEN:     xf_len     <= cfg_data[23:0];
          REG_FI_LEN:     fi_len     <= cfg_data[23:0];
          REG_FO_OFF:     fo_off     <= cfg_data;
          REG_FO_OFF_REP: fo_off_rep <= cfg_data;
          REG_FO_LEN:     fo_len     <= cfg_data[23:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        case (cmd_code)
          CMD_BEGIN: begin
            xf_pos        <= '0;
            fi_pos        <= '0;
            elapsed       <= '0;
            use_rep       <= 1'b0;
            outgoing_live <= entry_seen && (xf_len != 24'd0);
            entry_seen    <= 1'b1;
          end
          CMD_REPEAT: begin
            elapsed <= '0;
            use_rep <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.prep) begin
        xf <= outgoing_live && (xf_len != 24'd0);
        if (xf_len == 24'd0) begin
          outgoing_live <= 1'b0;
        end
      end
      if (cmd.finish) begin
        xf_pos  <= xf_inc;
        elapsed <= el_inc;
        if (fi_on) begin
          fi_pos <= fi_inc;
        end
        if (outgoing_live && xf_wrap) begin
          outgoing_live <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_il <= in_left;
      s_ir <= in_right;
      s_ol <= old_left;
      s_or <= old_right;
    end
    if (cmd.prep) begin
      g    <= gain_level;
      gout <= '0;
    end
    if (cmd.div_load) begin
      sat <= num >= NW'(den);
      rem <= num[23:0];
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (r2 >= {1'b0, den}) begin
        rem <= 24'(r2 - {1'b0, den});
        quo <= {quo[13:0], 1'b1};
      end else begin
        rem <= r2[23:0];
        quo <= {quo[13:0], 1'b0};
      end
    end
    if (cmd.apply) begin
      g <= gprod[30:15];
      if (cmd.fsel == F_XF) begin
        gout <= goprod[30:15];
      end
    end
    if (cmd.mul_in) begin
      p_in <= PW'(mix_in) * PW'($signed({1'b0, g}));
    end
    if (cmd.mul_old) begin
      p_old <= PW'(mix_old) * PW'($signed({1'b0, gout}));
    end
    if (cmd.sum) begin
      neg <= x[XW-1];
      a   <= x[XW-1] ? XW'(0) - XW'(x) : XW'(x);
    end
    if (cmd.clip_a) begin
      lin_zone <= a <= ONE;
      smag     <= smag_w[15:0];
      t_lo     <= TANH_TAB[lo_idx];
      t_hi     <= TANH_TAB[hi_idx];
      frac     <= big ? 16'd0 : fe_frac[15:0];
    end
    if (cmd.clip_b) begin
      prod <= 47'(t_hi - t_lo) * 47'(frac);
    end
    if (cmd.clip_c && !cmd.chan) begin
      res_l <= res;
    end
    if (cmd.finish) begin
      out_right <= res;
      out_left  <= res_l;
    end
  end

endmodule

FILE: src/crossfade_fade_gain_soft_clip.sv
// ----------------------------------------------------------------------------
// crossfade_fade_gain_soft_clip
// Stereo gain envelope (crossfade, fade-in, fade-out) with soft clipping.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  input   | in_valid, in_ready, cmd, in/old left and right | request in
//  output  | out_valid, out_ready, out_left, out_right      | request out
//  config  | cfg_we, cfg_index, cfg_data                    | write only
//
// A command request is accepted while idle and gives no result. A frame
// runs from acceptance through one 15-step divide for each active gain
// factor on the shared divider, then the per-channel multiply and clip
// steps, and then posts its result to the output register.
// The output register lets a new request enter while a result waits; a frame
// completes only once that register is free.
// Reset is synchronous and restores register defaults and envelope state.
module crossfade_fade_gain_soft_clip
  import cfgsc_pkg::*;
#(
  parameter int COUNT_WIDTH      = 24,
  parameter int SAMPLE_WIDTH     = 24,
  parameter int TANH_TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [24:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right,
  input  logic signed [SAMPLE_WIDTH-1:0] old_left,
  input  logic signed [SAMPLE_WIDTH-1:0] old_right,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_left,
  output logic signed [15:0]             out_right
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  cfgsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (ctl)
  );

  cfgsc_dp #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_code  (cmd),
    .in_left   (in_left),
    .in_right  (in_right),
    .old_left  (old_left),
    .old_right (old_right),
    .out_left  (out_left),
    .out_right (out_right),
    .cmd       (ctl),
    .stat      (stat)
  );

endmodule
